### hdl/keyboard_boot_report_decode_macros.svh
// Assertion macros shared by the keyboard report decoder.
`ifndef KEYBOARD_BOOT_REPORT_DECODE_MACROS_SVH
`define KEYBOARD_BOOT_REPORT_DECODE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define KBD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("keyboard decoder check failed");

// Next-cycle implication, disabled while reset is held.
`define KBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("keyboard decoder check failed");

`endif

### hdl/kbd_pkg.sv
// Types and constants of the keyboard boot-report decoder.
`timescale 1ns / 1ps

package kbd_pkg;

    localparam int KEY_WORDS   = 8;
    localparam int WORD_IDX_W  = 3;
    localparam int WORD_BITS   = 32;
    localparam int MOD_BITS    = 16;
    localparam int USAGE_BITS  = 8;
    localparam int MAX_KEYS    = 6;

    localparam logic [3:0] TYPE_KEYBOARD = 4'd4;

    typedef logic [WORD_IDX_W-1:0] t_word_idx;
    typedef logic [USAGE_BITS-1:0] t_usage;

    typedef struct packed {
        logic [3:0]          report_type;
        logic [MOD_BITS-1:0] modifiers;
        t_usage              usage0;
        t_usage              usage1;
        t_usage              usage2;
        t_usage              usage3;
        t_usage              usage4;
        t_usage              usage5;
    } t_report;

    typedef struct packed {
        t_word_idx            word_index;
        logic [WORD_BITS-1:0] keys_down;
        logic [WORD_BITS-1:0] keys_new;
        logic [WORD_BITS-1:0] keys_gone;
        logic [MOD_BITS-1:0]  mods_now;
        logic [MOD_BITS-1:0]  mods_new;
        logic [MOD_BITS-1:0]  mods_gone;
        logic                 present;
        logic                 last;
    } t_result;

endpackage

### hdl/kbd_channels.sv
// Valid/ready channel interfaces for reports in and key-map words out.
`timescale 1ns / 1ps

interface kbd_report_if;
    import kbd_pkg::*;

    logic    valid;
    logic    ready;
    t_report payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface kbd_result_if;
    import kbd_pkg::*;

    logic    valid;
    logic    ready;
    t_result payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### hdl/kbd_fifo.sv
// Two-entry queue between the report front end and the word generator.
`timescale 1ns / 1ps

module kbd_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_not_full,
    input  logic             i_pop,
    output logic             o_not_empty,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_count;
    logic [1:0]       n_count;
    logic             push_ok;
    logic             pop_ok;

    assign o_not_full  = (r_count != 2'd2);
    assign o_not_empty = (r_count != 2'd0);
    assign o_data      = r_mem[r_rptr];
    assign push_ok     = i_push && o_not_full;
    assign pop_ok      = i_pop && o_not_empty;

    always_comb begin
        n_count = r_count;
        if (push_ok && !pop_ok) begin
            n_count = r_count + 2'd1;
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (push_ok) begin
                r_wptr <= ~r_wptr;
            end
            if (pop_ok) begin
                r_rptr <= ~r_rptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wptr] <= i_data;
        end
    end
endmodule

### hdl/kbd_front.sv
// Report front end: accepts a report, checks its type and packs it for the queue.
`timescale 1ns / 1ps

module kbd_front #(
    parameter int USAGE_SLOTS = 6
) (
    kbd_report_if.sink                          i_report,
    input  logic                                i_q_ready,
    output logic                                o_q_push,
    output logic [1+kbd_pkg::MOD_BITS+kbd_pkg::USAGE_BITS*USAGE_SLOTS-1:0] o_q_entry
);
    import kbd_pkg::*;

    t_usage                             all_usage [MAX_KEYS];
    logic [USAGE_SLOTS-1:0][USAGE_BITS-1:0] kept_usage;
    logic                               is_kbd;
    logic [MOD_BITS-1:0]                kept_mods;

    assign i_report.ready = i_q_ready;
    assign o_q_push       = i_report.valid && i_q_ready;

    assign all_usage[0] = i_report.payload.usage0;
    assign all_usage[1] = i_report.payload.usage1;
    assign all_usage[2] = i_report.payload.usage2;
    assign all_usage[3] = i_report.payload.usage3;
    assign all_usage[4] = i_report.payload.usage4;
    assign all_usage[5] = i_report.payload.usage5;

    assign is_kbd = (i_report.payload.report_type == TYPE_KEYBOARD);

    // An absent keyboard is queued as an empty report, which releases every key.
    always_comb begin
        kept_mods = is_kbd ? i_report.payload.modifiers : '0;
        for (int k = 0; k < USAGE_SLOTS; k++) begin
            kept_usage[k] = is_kbd ? all_usage[k] : '0;
        end
    end

    assign o_q_entry = {is_kbd, kept_mods, kept_usage};
endmodule

### hdl/kbd_back.sv
// Word generator: expands one queued report into eight key-map words with edges.
`timescale 1ns / 1ps

module kbd_back #(
    parameter int USAGE_SLOTS = 6
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_valid,
    input  logic [1+kbd_pkg::MOD_BITS+kbd_pkg::USAGE_BITS*USAGE_SLOTS-1:0] i_q_entry,
    output logic o_q_pop,
    kbd_result_if.source o_result
);
    import kbd_pkg::*;

    localparam int ENTRY_W = 1 + MOD_BITS + USAGE_BITS * USAGE_SLOTS;

    logic [WORD_BITS-1:0]               r_prior_map [KEY_WORDS];
    logic [MOD_BITS-1:0]                r_prior_mods;
    t_word_idx                          r_word;
    logic                               r_out_valid;
    t_result                            r_out;

    logic                               ent_present;
    logic [MOD_BITS-1:0]                ent_mods;
    logic [USAGE_SLOTS-1:0][USAGE_BITS-1:0] ent_usage;
    logic [WORD_BITS-1:0]               map_word;
    logic [WORD_BITS-1:0]               prev_word;
    logic                               load;
    logic                               at_last;
    t_result                            n_out;

    assign ent_present = i_q_entry[ENTRY_W-1];
    assign ent_mods    = i_q_entry[ENTRY_W-2 -: MOD_BITS];
    assign ent_usage   = i_q_entry[USAGE_BITS*USAGE_SLOTS-1:0];

    assign at_last   = (r_word == WORD_IDX_W'(KEY_WORDS - 1));
    assign load      = i_q_valid && (!r_out_valid || o_result.ready);
    assign o_q_pop   = load && at_last;
    assign prev_word = r_prior_map[r_word];

    // Bits of the current word come from nonzero usages whose upper three bits select it.
    always_comb begin
        map_word = '0;
        for (int k = 0; k < USAGE_SLOTS; k++) begin
            if (ent_usage[k] != '0 && ent_usage[k][7:5] == r_word) begin
                map_word[ent_usage[k][4:0]] = 1'b1;
            end
        end
    end

    always_comb begin
        n_out.word_index = r_word;
        n_out.keys_down  = map_word;
        n_out.keys_new   = map_word & ~prev_word;
        n_out.keys_gone  = ~map_word & prev_word;
        n_out.mods_now   = ent_mods;
        n_out.mods_new   = ent_mods & ~r_prior_mods;
        n_out.mods_gone  = ~ent_mods & r_prior_mods;
        n_out.present    = ent_present;
        n_out.last       = at_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word       <= '0;
            r_out_valid  <= 1'b0;
            r_prior_mods <= '0;
            for (int w = 0; w < KEY_WORDS; w++) begin
                r_prior_map[w] <= '0;
            end
        end else begin
            if (load) begin
                r_out_valid          <= 1'b1;
                r_word               <= WORD_IDX_W'(r_word + 1'b1);
                r_prior_map[r_word]  <= map_word;
                if (at_last) begin
                    r_prior_mods <= ent_mods;
                end
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    assign o_result.valid   = r_out_valid;
    assign o_result.payload = r_out;
endmodule

### hdl/keyboard_boot_report_decode.sv
// Top level of the keyboard boot-report decoder.
//
//   Channel    Dir   Carries                                   One per
//   i_report   in    type, modifiers, six usage IDs            report
//   o_result   out   key-map word, key and modifier edges      map word (8 per report)
//
// Each report yields eight output items, one per cycle from the word counter
// in the generator when the output is not stalled.
// A two-entry queue holds the report being expanded and one more waiting
// behind it; an output stall holds the generator on its current word.
// Synchronous active-low reset clears the stored key map, modifiers and queue.
`timescale 1ns / 1ps

module keyboard_boot_report_decode #(
    parameter int USAGE_SLOTS = 6
) (
    input logic          i_clk,
    input logic          i_rst_n,
    kbd_report_if.sink   i_report,
    kbd_result_if.source o_result
);
    import kbd_pkg::*;

    `include "keyboard_boot_report_decode_macros.svh"

    localparam int ENTRY_W = 1 + MOD_BITS + USAGE_BITS * USAGE_SLOTS;

    logic               q_push;
    logic               q_not_full;
    logic               q_not_empty;
    logic               q_pop;
    logic [ENTRY_W-1:0] q_in;
    logic [ENTRY_W-1:0] q_out;
    logic               out_last;
    logic               out_absent;
    logic               out_mid_taken;
    logic               last_idx_ok;
    logic               absent_clear_ok;

    kbd_front #(
        .USAGE_SLOTS (USAGE_SLOTS)
    ) u_front (
        .i_report  (i_report),
        .i_q_ready (q_not_full),
        .o_q_push  (q_push),
        .o_q_entry (q_in)
    );

    kbd_fifo #(
        .WIDTH (ENTRY_W)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_data      (q_in),
        .o_not_full  (q_not_full),
        .i_pop       (q_pop),
        .o_not_empty (q_not_empty),
        .o_data      (q_out)
    );

    kbd_back #(
        .USAGE_SLOTS (USAGE_SLOTS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_not_empty),
        .i_q_entry (q_out),
        .o_q_pop   (q_pop),
        .o_result  (o_result)
    );

    assign out_last      = o_result.valid && o_result.payload.last;
    assign out_absent    = o_result.valid && !o_result.payload.present;
    assign out_mid_taken = o_result.valid && o_result.ready && !o_result.payload.last;
    assign last_idx_ok   = (o_result.payload.word_index == WORD_IDX_W'(KEY_WORDS - 1));
    assign absent_clear_ok = (o_result.payload.keys_down == '0) &&
                             (o_result.payload.keys_new == '0) &&
                             (o_result.payload.mods_now == '0) &&
                             (o_result.payload.mods_new == '0);

    // The last flag marks the final word of the map.
    `KBD_ASSERT_NOW(a_last_word, i_clk, i_rst_n, out_last, last_idx_ok)

    // An absent keyboard shows nothing held and nothing pressed.
    `KBD_ASSERT_NOW(a_absent_clear, i_clk, i_rst_n, out_absent, absent_clear_ok)

    // Once a report has started, its words follow without a gap.
    `KBD_ASSERT_NEXT(a_run_continues, i_clk, i_rst_n, out_mid_taken, o_result.valid)

    // The queue is popped only while it holds an entry; the generator pops it on the final word of a report.
    `KBD_ASSERT_NOW(a_pop_on_last, i_clk, i_rst_n, q_pop, q_not_empty)
endmodule

### sim/keyboard_boot_report_decode_tb.sv
// Self-checking testbench for the keyboard boot-report decoder.
`timescale 1ns / 1ps

module keyboard_boot_report_decode_tb;
    import kbd_pkg::*;

    localparam int REPORT_SLOTS   = 6;
    localparam int RANDOM_REPORTS = 445;
    localparam int LONG_HOLD      = 200;
    localparam logic [255:0] KEY1 = 256'd1;

    typedef struct {
        t_report             rpt;
        bit                  literal;
        logic [255:0]        down;
        logic [255:0]        pressed;
        logic [255:0]        lifted;
        logic [MOD_BITS-1:0] m_now;
        logic [MOD_BITS-1:0] m_new;
        logic [MOD_BITS-1:0] m_gone;
        logic                kbd;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    kbd_report_if report_ch ();
    kbd_result_if result_ch ();

    keyboard_boot_report_decode #(
        .USAGE_SLOTS(REPORT_SLOTS)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_report (report_ch),
        .o_result (result_ch)
    );

    // Copy of the stored map and modifiers, as the block should hold them.
    logic [WORD_BITS-1:0] held_map [KEY_WORDS];
    logic [MOD_BITS-1:0]  held_mods;
    t_result              pred_words [KEY_WORDS];
    t_result              expected_words [$];

    int  reports_sent;
    int  absent_reports;
    int  words_checked = 0;
    int  bad_words = 0;
    int  input_stalls = 0;
    int  rx_cycles = 0;
    int  stall_left = 0;
    logic hold_off;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Works out the eight map words for one report and updates the held state.
    function automatic void decode_report(input t_report r);
        logic [WORD_BITS-1:0] map_now [KEY_WORDS];
        t_usage               usages [MAX_KEYS];
        logic [MOD_BITS-1:0]  mods;
        logic [MOD_BITS-1:0]  m_new;
        logic [MOD_BITS-1:0]  m_gone;
        logic                 kbd;
        kbd    = (r.report_type == TYPE_KEYBOARD);
        usages = '{r.usage0, r.usage1, r.usage2, r.usage3, r.usage4, r.usage5};
        for (int w = 0; w < KEY_WORDS; w++) map_now[w] = '0;
        if (kbd) begin
            for (int k = 0; k < REPORT_SLOTS; k++) begin
                if (usages[k] != '0) map_now[usages[k][7:5]][usages[k][4:0]] = 1'b1;
            end
            mods   = r.modifiers;
            m_new  = mods & ~held_mods;
            m_gone = ~mods & held_mods;
        end else begin
            mods   = '0;
            m_new  = '0;
            m_gone = held_mods;
        end
        for (int w = 0; w < KEY_WORDS; w++) begin
            pred_words[w] = '{word_index: t_word_idx'(w),
                              keys_down:  map_now[w],
                              keys_new:   map_now[w] & ~held_map[w],
                              keys_gone:  ~map_now[w] & held_map[w],
                              mods_now:   mods,
                              mods_new:   m_new,
                              mods_gone:  m_gone,
                              present:    kbd,
                              last:       (w == KEY_WORDS - 1)};
            held_map[w] = map_now[w];
        end
        held_mods = mods;
    endfunction

    function automatic t_stim_row make_row(input logic [3:0] rtype,
                                           input logic [MOD_BITS-1:0] mods,
                                           input t_usage u0, input t_usage u1,
                                           input t_usage u2, input t_usage u3,
                                           input t_usage u4, input t_usage u5);
        t_stim_row row;
        row = '{rpt: '{rtype, mods, u0, u1, u2, u3, u4, u5}, literal: 1'b0,
                down: '0, pressed: '0, lifted: '0, m_now: '0, m_new: '0,
                m_gone: '0, kbd: 1'b0};
        return row;
    endfunction

    function automatic t_usage random_usage(input t_usage kept);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40) return kept;
        if (pick < 65) return '0;
        return t_usage'($urandom_range(1, 255));
    endfunction

    // Mostly keyboard reports that carry keys and modifiers over from the
    // previous one, with some absent reports and some fully random ones.
    function automatic t_report random_report(input t_report prev);
        t_report r;
        int      kind;
        int      pick;
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
            r.report_type = 4'($urandom);
            r.modifiers   = 16'($urandom);
            r.usage0 = 8'($urandom);
            r.usage1 = 8'($urandom);
            r.usage2 = 8'($urandom);
            r.usage3 = 8'($urandom);
            r.usage4 = 8'($urandom);
            r.usage5 = 8'($urandom);
            return r;
        end
        r = prev;
        if (kind < 15) begin
            r.report_type = 4'($urandom_range(5, 19));
            r.modifiers   = 16'($urandom);
            return r;
        end
        r.report_type = TYPE_KEYBOARD;
        pick = $urandom_range(0, 2);
        if (pick == 1) begin
            r.modifiers = prev.modifiers ^ (16'd1 << $urandom_range(0, 15));
        end else if (pick == 2) begin
            r.modifiers = 16'($urandom);
        end
        r.usage0 = random_usage(prev.usage0);
        r.usage1 = random_usage(prev.usage1);
        r.usage2 = random_usage(prev.usage2);
        r.usage3 = random_usage(prev.usage3);
        r.usage4 = random_usage(prev.usage4);
        r.usage5 = random_usage(prev.usage5);
        // A repeated usage now and then.
        if ($urandom_range(0, 9) == 0) r.usage3 = r.usage1;
        return r;
    endfunction

    // Runs of items without gaps alternate with runs of mixed gaps.
    function automatic int pick_gap(input int idx);
        int pick;
        if ((idx / 50) % 3 == 1) return 0;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic offer_report(input t_stim_row row, input int gap);
        t_result w;
        if (gap > 0) begin
            report_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        report_ch.valid   <= 1'b1;
        report_ch.payload <= row.rpt;
        do @(posedge i_clk); while (!report_ch.ready);
        decode_report(row.rpt);
        for (int i = 0; i < KEY_WORDS; i++) begin
            w = pred_words[i];
            if (row.literal) begin
                w.keys_down = row.down[i*WORD_BITS +: WORD_BITS];
                w.keys_new  = row.pressed[i*WORD_BITS +: WORD_BITS];
                w.keys_gone = row.lifted[i*WORD_BITS +: WORD_BITS];
                w.mods_now  = row.m_now;
                w.mods_new  = row.m_new;
                w.mods_gone = row.m_gone;
                w.present   = row.kbd;
            end
            expected_words.push_back(w);
        end
        reports_sent++;
        if (row.rpt.report_type != TYPE_KEYBOARD) absent_reports++;
    endtask

    function automatic string show_word(input t_result w);
        return $sformatf("idx=%0d down=%h new=%h gone=%h mods=%h/%h/%h present=%b last=%b",
                         w.word_index, w.keys_down, w.keys_new, w.keys_gone,
                         w.mods_now, w.mods_new, w.mods_gone, w.present, w.last);
    endfunction

    function automatic bit words_differ(input t_result a, input t_result b);
        return (a.word_index !== b.word_index) || (a.keys_down !== b.keys_down) ||
               (a.keys_new !== b.keys_new) || (a.keys_gone !== b.keys_gone) ||
               (a.mods_now !== b.mods_now) || (a.mods_new !== b.mods_new) ||
               (a.mods_gone !== b.mods_gone) || (a.present !== b.present) ||
               (a.last !== b.last);
    endfunction

    // Output side: checks each item taken and decides the next ready level.
    always @(posedge i_clk) begin
        t_result exp_w;
        if (i_rst_n) begin
            if (report_ch.valid && !report_ch.ready) input_stalls++;
            if (result_ch.valid && result_ch.ready) begin
                if (expected_words.size() == 0) begin
                    bad_words++;
                    if (bad_words <= 10) begin
                        $display("unexpected map word: %s", show_word(result_ch.payload));
                    end
                end else begin
                    exp_w = expected_words.pop_front();
                    words_checked++;
                    if (words_differ(exp_w, result_ch.payload)) begin
                        bad_words++;
                        if (bad_words <= 10) begin
                            $display("mismatch at %0t", $realtime);
                            $display("  expected %s", show_word(exp_w));
                            $display("  actual   %s", show_word(result_ch.payload));
                        end
                    end
                end
            end
        end
        rx_cycles++;
        if (hold_off) begin
            result_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            result_ch.ready <= 1'b0;
        end else if ((rx_cycles / 300) % 3 == 2) begin
            result_ch.ready <= 1'b1;
        end else begin
            case ($urandom_range(0, 99)) inside
                [0:69]:  result_ch.ready <= 1'b1;
                [70:96]: begin
                    stall_left = $urandom_range(0, 2);
                    result_ch.ready <= 1'b0;
                end
                default: begin
                    stall_left = $urandom_range(10, 40);
                    result_ch.ready <= 1'b0;
                end
            endcase
        end
    end

    // One long hold on the output while reports keep coming, to back up the input.
    initial begin
        hold_off <= 1'b0;
        wait (reports_sent >= 60);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (LONG_HOLD) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        t_stim_row directed_rows [$];
        t_stim_row row;
        t_report   prev;

        report_ch.valid   <= 1'b0;
        report_ch.payload <= '0;
        i_rst_n           <= 1'b0;
        for (int w = 0; w < KEY_WORDS; w++) held_map[w] = '0;
        held_mods      = '0;
        reports_sent   = 0;
        absent_reports = 0;

        // Lowest, middle and highest usages from the reset state.
        row = make_row(TYPE_KEYBOARD, 16'hFFFF, 8'h01, 8'h20, 8'hFF, 8'h00, 8'h00, 8'h00);
        row.literal = 1'b1;
        row.down    = (KEY1 << 1) | (KEY1 << 32) | (KEY1 << 255);
        row.pressed = row.down;
        row.m_now   = 16'hFFFF;
        row.m_new   = 16'hFFFF;
        row.kbd     = 1'b1;
        directed_rows.push_back(row);
        // Everything released.
        row = make_row(TYPE_KEYBOARD, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        row.literal = 1'b1;
        row.lifted  = (KEY1 << 1) | (KEY1 << 32) | (KEY1 << 255);
        row.m_gone  = 16'hFFFF;
        row.kbd     = 1'b1;
        directed_rows.push_back(row);
        // The same usage in every slot sets one bit.
        row = make_row(TYPE_KEYBOARD, 16'h00A5, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        row.literal = 1'b1;
        row.down    = KEY1 << 255;
        row.pressed = KEY1 << 255;
        row.m_now   = 16'h00A5;
        row.m_new   = 16'h00A5;
        row.kbd     = 1'b1;
        directed_rows.push_back(row);
        // Keyboard gone: held keys and modifiers show as released.
        row = make_row(4'hF, 16'hFFFF, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06);
        row.literal = 1'b1;
        row.lifted  = KEY1 << 255;
        row.m_gone  = 16'h00A5;
        directed_rows.push_back(row);
        // Still absent, nothing left to release.
        row = make_row(4'h0, 16'h1234, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66);
        row.literal = 1'b1;
        directed_rows.push_back(row);
        directed_rows.push_back(make_row(TYPE_KEYBOARD, 16'h5555,
                                         8'h80, 8'h40, 8'h10, 8'h08, 8'h04, 8'h02));
        directed_rows.push_back(make_row(TYPE_KEYBOARD, 16'hAAAA,
                                         8'h7F, 8'hBF, 8'hDF, 8'hEF, 8'hF7, 8'hFB));
        directed_rows.push_back(make_row(TYPE_KEYBOARD, 16'hAAAA,
                                         8'h7F, 8'hBF, 8'hDF, 8'hEF, 8'hF7, 8'hFB));
        directed_rows.push_back(make_row(TYPE_KEYBOARD, 16'hFFFF,
                                         8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hE1));
        directed_rows.push_back(make_row(TYPE_KEYBOARD, 16'h8001,
                                         8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26));
        directed_rows.push_back(make_row(4'h3, 16'hFFFF,
                                         8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        directed_rows.push_back(make_row(TYPE_KEYBOARD, 16'h0100,
                                         8'h1F, 8'h3F, 8'h5F, 8'h7F, 8'h9F, 8'hBF));
        directed_rows.push_back(make_row(4'h5, 16'h0000,
                                         8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        directed_rows.push_back(make_row(TYPE_KEYBOARD, 16'h7FFE,
                                         8'hC0, 8'hA0, 8'h60, 8'h00, 8'h9C, 8'h33));
        directed_rows.push_back(make_row(4'hC, 16'hF00F,
                                         8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        directed_rows.push_back(make_row(4'h8, 16'h0F0F,
                                         8'hAA, 8'h55, 8'h00, 8'h00, 8'h00, 8'h00));
        directed_rows.push_back(make_row(4'hB, 16'h3C3C,
                                         8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        directed_rows.push_back(make_row(TYPE_KEYBOARD, 16'h0000,
                                         8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) offer_report(directed_rows[i], pick_gap(i));

        prev = directed_rows[directed_rows.size() - 1].rpt;
        for (int n = 0; n < RANDOM_REPORTS; n++) begin
            row     = make_row(4'h0, '0, '0, '0, '0, '0, '0, '0);
            row.rpt = random_report(prev);
            prev    = row.rpt;
            offer_report(row, pick_gap(n));
        end
        report_ch.valid <= 1'b0;

        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Sent %0d reports (%0d without a keyboard), checked %0d map words.",
                 reports_sent, absent_reports, words_checked);
        $display("Input was held off for %0d cycles; %0d bad words.",
                 input_stalls, bad_words);
        if (bad_words == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### keyboard_boot_report_decode.f
+incdir+hdl
hdl/kbd_pkg.sv
hdl/kbd_channels.sv
hdl/kbd_fifo.sv
hdl/kbd_front.sv
hdl/kbd_back.sv
hdl/keyboard_boot_report_decode.sv
sim/keyboard_boot_report_decode_tb.sv
